@@ rtl/chkv_pkg.sv @@
// Shared constants, codes and control types of the chained hash index.
`timescale 1ns / 1ps
`default_nettype none
package chkv_pkg;
   localparam int KEY_BYTES  = 8;
   localparam int KEY_W      = 8 * KEY_BYTES;
   localparam int LEN_W      = $clog2(KEY_BYTES + 1);
   localparam int BUCKETS    = 1024;
   localparam int BKT_W      = $clog2(BUCKETS);
   localparam int NODES      = 1024;
   localparam int ID_W       = 11;
   localparam int HASH_W     = 32;
   localparam int CSR_W      = 11;
   localparam logic [ID_W-1:0]   NIL_ID     = 11'h7FF;
   localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;
   localparam logic [3:0]        KEY_SIZE_RESET = 4'd8;
   localparam logic [CSR_W-1:0]  MAX_REC_RESET  = 11'd1024;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0, OP_SELECT = 2'd1, OP_CLEAR = 2'd2, OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RS_OK = 2'd0, RS_TOO_LONG = 2'd1, RS_FULL = 2'd2, RS_NOT_FOUND = 2'd3
   } rsp_status_type;

   typedef enum logic {
      CSR_KEY_SIZE = 1'b0, CSR_MAX_RECORDS = 1'b1
   } csr_idx_type;

   typedef enum logic [4:0] {
      DP_NOP, DP_SWEEP, DP_LOAD, DP_HASH, DP_HEAD_RD, DP_HEAD_CAP, DP_NODE_RD,
      DP_NODE_NEXT, DP_VAL_WR, DP_VAL_RD, DP_VAL_CAP, DP_FREE_RD, DP_LINK_NEW,
      DP_CLR_B_RD, DP_CLR_B_CAP, DP_CLR_B_END, DP_CLR_N_RD, DP_CLR_N_MOVE,
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type      op;
      rsp_status_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic   hash_done;
      logic   too_long;
      logic   cur_nil;
      logic   key_hit;
      logic   free_nil;
      logic   idx_last;
      logic   rsp_free;
      op_type op;
   } dp_stat_type;
endpackage
`default_nettype wire

@@ rtl/chkv_if.sv @@
// Handshake channel interfaces: request, response and register write.
`timescale 1ns / 1ps
`default_nettype none
interface chkv_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       op;
   logic [chkv_pkg::KEY_W-1:0]       key;
   logic signed [chkv_pkg::KEY_W-1:0] value;
   modport source (output valid, op, key, value, input ready);
   modport sink (input valid, op, key, value, output ready);
endinterface

interface chkv_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       status;
   logic signed [chkv_pkg::KEY_W-1:0] data;
   modport source (output valid, status, data, input ready);
   modport sink (input valid, status, data, output ready);
endinterface

interface chkv_csr_if;
   logic                        valid;
   logic                        ready;
   logic                        index;
   logic [chkv_pkg::CSR_W-1:0]  wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

@@ rtl/chkv_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module chkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ rtl/chkv_ctrl.sv @@
// Controller state machine: sequences hashing, chain walks, clear and init.
`timescale 1ns / 1ps
`default_nettype none
module chkv_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 csr_wr,
   input  wire chkv_pkg::dp_stat_type stat,
   output chkv_pkg::dp_cmd_type      cmd
);
   import chkv_pkg::*;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_HASH, S_HEAD, S_HEADW, S_CHK, S_CMP, S_VALW, S_FREEW,
      S_CLRB, S_CLRBW, S_CLRN, S_CLRNW, S_DONE
   } state_type;

   state_type      state_ff, state_in;
   rsp_status_type code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd.op   = DP_NOP;
      cmd.code = code_ff;
      case (state_ff)
         S_INIT: begin
            cmd.op = DP_SWEEP;
            if (stat.idx_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            code_in = RS_OK;
            if (stat.op == OP_CLEAR) begin
               state_in = S_CLRB;
            end else if (stat.op == OP_NONE) begin
               state_in = S_DONE;
            end else if (stat.op == OP_INSERT && stat.too_long) begin
               code_in  = RS_TOO_LONG;
               state_in = S_DONE;
            end else if (stat.hash_done) begin
               state_in = S_HEAD;
            end else begin
               cmd.op = DP_HASH;
            end
         end
         S_HEAD: begin
            cmd.op   = DP_HEAD_RD;
            state_in = S_HEADW;
         end
         S_HEADW: begin
            cmd.op   = DP_HEAD_CAP;
            state_in = S_CHK;
         end
         S_CHK: begin
            if (!stat.cur_nil) begin
               cmd.op   = DP_NODE_RD;
               state_in = S_CMP;
            end else if (stat.op == OP_SELECT) begin
               code_in  = RS_NOT_FOUND;
               state_in = S_DONE;
            end else if (stat.free_nil) begin
               code_in  = RS_FULL;
               state_in = S_DONE;
            end else begin
               cmd.op   = DP_FREE_RD;
               state_in = S_FREEW;
            end
         end
         S_CMP: begin
            if (!stat.key_hit) begin
               cmd.op   = DP_NODE_NEXT;
               state_in = S_CHK;
            end else if (stat.op == OP_SELECT) begin
               cmd.op   = DP_VAL_RD;
               state_in = S_VALW;
            end else begin
               cmd.op   = DP_VAL_WR;
               state_in = S_DONE;
            end
         end
         S_VALW: begin
            cmd.op   = DP_VAL_CAP;
            state_in = S_DONE;
         end
         S_FREEW: begin
            cmd.op   = DP_LINK_NEW;
            state_in = S_DONE;
         end
         S_CLRB: begin
            cmd.op   = DP_CLR_B_RD;
            state_in = S_CLRBW;
         end
         S_CLRBW: begin
            cmd.op   = DP_CLR_B_CAP;
            state_in = S_CLRN;
         end
         S_CLRN: begin
            if (stat.cur_nil) begin
               cmd.op   = DP_CLR_B_END;
               state_in = stat.idx_last ? S_DONE : S_CLRB;
            end else begin
               cmd.op   = DP_CLR_N_RD;
               state_in = S_CLRNW;
            end
         end
         S_CLRNW: begin
            cmd.op   = DP_CLR_N_MOVE;
            state_in = S_CLRN;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.op   = DP_RESULT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
      // a register write rebuilds the table from scratch
      if (csr_wr) begin
         state_in = S_INIT;
         cmd.op   = DP_NOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         code_ff  <= RS_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && !csr_wr;
endmodule
`default_nettype wire

@@ rtl/chkv_dp.sv @@
// Datapath: key trim, byte-serial hash, node pool memories and result register.
`timescale 1ns / 1ps
`default_nettype none
module chkv_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire chkv_pkg::dp_cmd_type          cmd,
   output chkv_pkg::dp_stat_type              stat,
   input  wire logic [1:0]                    req_op,
   input  wire logic [chkv_pkg::KEY_W-1:0]    req_key,
   input  wire logic signed [chkv_pkg::KEY_W-1:0] req_value,
   input  wire logic                          csr_wr,
   input  wire logic                          csr_index,
   input  wire logic [chkv_pkg::CSR_W-1:0]    csr_wdata,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [1:0]                         rsp_status,
   output logic signed [chkv_pkg::KEY_W-1:0]  rsp_data
);
   import chkv_pkg::*;

   logic [3:0]         key_size_ff;
   logic [CSR_W-1:0]   max_rec_ff;
   logic [BKT_W-1:0]   idx_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   value_ff;
   logic [LEN_W-1:0]   len_ff;
   op_type             op_ff;
   logic [HASH_W-1:0]  hash_ff;
   logic [ID_W-1:0]    cur_ff, head_ff, free_ff;
   logic [KEY_W-1:0]   data_ff;
   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [KEY_W-1:0]   rsp_data_ff;

   // trimmed key and its length
   logic [KEY_W-1:0]   trim_key;
   logic [LEN_W-1:0]   trim_len;
   logic               stop;
   always_comb begin
      trim_key = '0;
      trim_len = '0;
      stop     = 1'b0;
      for (int i = 0; i < KEY_BYTES; i++) begin
         if (req_key[8*i +: 8] == 8'd0) stop = 1'b1;
         if (!stop) begin
            trim_key[8*i +: 8] = req_key[8*i +: 8];
            trim_len           = LEN_W'(i + 1);
         end
      end
   end

   logic [7:0]        hash_byte;
   logic [HASH_W-1:0] hash_prod;
   assign hash_byte = key_ff[{idx_ff[LEN_W-2:0], 3'b000} +: 8];
   assign hash_prod = hash_ff * HASH_PRIME;

   logic [ID_W-1:0] max_sat, sweep_next;
   assign max_sat    = (max_rec_ff > ID_W'(NODES)) ? ID_W'(NODES) : max_rec_ff;
   assign sweep_next = {1'b0, idx_ff} + ID_W'(1);

   logic               bh_we, ln_we, ky_we, vl_we;
   logic [BKT_W-1:0]   bh_addr, ln_addr, ky_addr, vl_addr;
   logic [ID_W-1:0]    bh_wdata, bh_rdata, ln_wdata, ln_rdata;
   logic [KEY_W-1:0]   ky_rdata, vl_wdata, vl_rdata;
   logic [BKT_W-1:0]   bucket;
   assign bucket = hash_ff[BKT_W-1:0];

   always_comb begin
      bh_we = 1'b0; ln_we = 1'b0; ky_we = 1'b0; vl_we = 1'b0;
      bh_addr = idx_ff;
      ln_addr = cur_ff[BKT_W-1:0];
      ky_addr = cur_ff[BKT_W-1:0];
      vl_addr = cur_ff[BKT_W-1:0];
      bh_wdata = NIL_ID;
      ln_wdata = free_ff;
      vl_wdata = value_ff;
      case (cmd.op)
         DP_SWEEP: begin
            bh_we    = 1'b1;
            ln_we    = 1'b1;
            ln_addr  = idx_ff;
            ln_wdata = (sweep_next < max_sat) ? sweep_next : NIL_ID;
         end
         DP_HEAD_RD:   bh_addr = bucket;
         DP_VAL_WR:    vl_we = 1'b1;
         DP_FREE_RD:   ln_addr = free_ff[BKT_W-1:0];
         DP_LINK_NEW: begin
            bh_we    = 1'b1;
            bh_addr  = bucket;
            bh_wdata = free_ff;
            ln_we    = 1'b1;
            ln_addr  = free_ff[BKT_W-1:0];
            ln_wdata = head_ff;
            ky_we    = 1'b1;
            ky_addr  = free_ff[BKT_W-1:0];
            vl_we    = 1'b1;
            vl_addr  = free_ff[BKT_W-1:0];
         end
         DP_CLR_B_END: bh_we = 1'b1;
         DP_CLR_N_MOVE: ln_we = 1'b1;
         default: ;
      endcase
   end

   chkv_ram #(.WIDTH(ID_W), .DEPTH(BUCKETS)) u_head (
      .clock(clock), .we(bh_we), .addr(bh_addr), .wdata(bh_wdata), .rdata(bh_rdata));
   chkv_ram #(.WIDTH(ID_W), .DEPTH(NODES)) u_link (
      .clock(clock), .we(ln_we), .addr(ln_addr), .wdata(ln_wdata), .rdata(ln_rdata));
   chkv_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_key (
      .clock(clock), .we(ky_we), .addr(ky_addr), .wdata(key_ff), .rdata(ky_rdata));
   chkv_ram #(.WIDTH(KEY_W), .DEPTH(NODES)) u_value (
      .clock(clock), .we(vl_we), .addr(vl_addr), .wdata(vl_wdata), .rdata(vl_rdata));

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff  <= KEY_SIZE_RESET;
         max_rec_ff   <= MAX_REC_RESET;
         idx_ff       <= '0;
         free_ff      <= NIL_ID;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && cmd.op != DP_RESULT) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            DP_SWEEP: begin
               idx_ff <= idx_ff + BKT_W'(1);
               if (idx_ff == BKT_W'(BUCKETS - 1)) begin
                  free_ff <= (max_sat != '0) ? '0 : NIL_ID;
               end
            end
            DP_LOAD: begin
               key_ff   <= trim_key;
               len_ff   <= trim_len;
               value_ff <= req_value;
               op_ff    <= op_type'(req_op);
               hash_ff  <= '0;
               idx_ff   <= '0;
               data_ff  <= '0;
            end
            DP_HASH: begin
               hash_ff <= hash_prod ^ {{(HASH_W-8){hash_byte[7]}}, hash_byte};
               idx_ff  <= idx_ff + BKT_W'(1);
            end
            DP_HEAD_CAP, DP_CLR_B_CAP: begin
               cur_ff  <= bh_rdata;
               head_ff <= bh_rdata;
            end
            DP_NODE_NEXT: cur_ff <= ln_rdata;
            DP_VAL_CAP:   data_ff <= vl_rdata;
            DP_LINK_NEW:  free_ff <= ln_rdata;
            DP_CLR_B_END: idx_ff <= idx_ff + BKT_W'(1);
            DP_CLR_N_MOVE: begin
               free_ff <= cur_ff;
               cur_ff  <= ln_rdata;
            end
            DP_RESULT: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= cmd.code;
               rsp_data_ff   <= data_ff;
            end
            default: ;
         endcase
         // register write: take the value and restart the rebuild sweep
         if (csr_wr) begin
            idx_ff <= '0;
            if (csr_index == CSR_KEY_SIZE) begin
               key_size_ff <= csr_wdata[3:0];
            end else begin
               max_rec_ff <= csr_wdata;
            end
         end
      end
   end

   always_comb begin
      stat.hash_done = ({{(BKT_W-LEN_W){1'b0}}, len_ff} == idx_ff);
      stat.too_long  = ({1'b0, len_ff} > {{(LEN_W-3){1'b0}}, key_size_ff});
      stat.cur_nil   = cur_ff[ID_W-1];
      stat.key_hit   = (ky_rdata == key_ff);
      stat.free_nil  = free_ff[ID_W-1];
      stat.idx_last  = (idx_ff == BKT_W'(BUCKETS - 1));
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
      stat.op        = op_ff;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
endmodule
`default_nettype wire

@@ rtl/chained_hash_key_value_index.sv @@
// Chained hash key to value index: top level joining controller and datapath.
// Insert and select hash the key byte by byte, then walk the chain of its bucket.
// Clear visits every bucket and returns each stored node to the free list.
// One request is in flight at a time; the result register lets the next request enter.
// Reset and every register write start a rebuild sweep of the head and link memories,
// during which no request is taken.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_key_value_index (
   input  wire logic clock,
   input  wire logic reset,
   chkv_req_if.sink   req_if,
   chkv_rsp_if.source rsp_if,
   chkv_csr_if.sink   csr_if
);
   import chkv_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic        csr_wr;

   assign csr_if.ready = 1'b1;
   assign csr_wr       = csr_if.valid;

   chkv_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_if.valid), .req_ready(req_if.ready),
      .csr_wr(csr_wr), .stat(stat), .cmd(cmd));

   chkv_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_op(req_if.op), .req_key(req_if.key), .req_value(req_if.value),
      .csr_wr(csr_wr), .csr_index(csr_if.index), .csr_wdata(csr_if.wdata),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
      .rsp_status(rsp_if.status), .rsp_data(rsp_if.data));

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request taken while another is in flight");

   a_rebuild_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> !req_if.ready)
      else $error("request taken during rebuild");

   a_result_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_RESULT) |-> (!rsp_if.valid || rsp_if.ready))
      else $error("result overwrites a pending response");
endmodule
`default_nettype wire
